[design/lfp_pkg.sv]
package lfp_pkg;

    // Frame geometry
    localparam int POINTS_PER_FRAME = 12;
    localparam int BODY_BYTES       = 45;

    localparam logic [7:0] HDR_FIRST  = 8'h54;
    localparam logic [7:0] HDR_SECOND = 8'h2C;

    // Body offsets: speed and start angle, then the points, then end angle and time
    localparam int PTS_BASE = 4;
    localparam int PTS_END  = PTS_BASE + 3 * POINTS_PER_FRAME;

    localparam int POS_W = $clog2(BODY_BYTES);
    localparam int IDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;

    localparam int IN_W  = 8;
    localparam int OUT_W = 104;

    // Frame queue between parser and record emitter
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  intensity;
        logic [15:0] distance;
    } lfp_point_t;

    typedef struct packed {
        lfp_point_t [POINTS_PER_FRAME-1:0] points;
        logic [7:0]                        crc;
        logic [15:0]                       frame_time;
        logic [15:0]                       sweep_stop;
        logic [15:0]                       sweep_start;
        logic [15:0]                       speed;
    } lfp_frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lfp_qstat_t;

endpackage

[design/lfp_front.sv]
module lfp_front
    import lfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    input  lfp_qstat_t       qstat,
    output logic             push,
    output lfp_frame_t       frame
);

    localparam logic [1:0] PH_SEEK1 = 2'd0;
    localparam logic [1:0] PH_SEEK2 = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;

    localparam logic [1:0] SUB_LOW  = 2'd0;
    localparam logic [1:0] SUB_HIGH = 2'd1;
    localparam logic [1:0] SUB_INT  = 2'd2;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BODY_BYTES - 1);
    localparam logic [IDX_W-1:0] PT_LAST  = IDX_W'(POINTS_PER_FRAME - 1);

    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       sub_reg, sub_next;
    logic [IDX_W-1:0] pt_reg, pt_next;
    logic [7:0]       low_reg, low_next;

    logic [15:0] hdr_reg  [4];
    logic [15:0] hdr_next [4];
    logic [15:0] dist_reg [POINTS_PER_FRAME];
    logic [15:0] dist_next[POINTS_PER_FRAME];
    logic [7:0]  inten_reg [POINTS_PER_FRAME];
    logic [7:0]  inten_next[POINTS_PER_FRAME];

    logic             accept;
    logic [POS_W-1:0] tail_rel;
    logic [15:0]      word;

    // Hold off only the CRC byte, and only while the frame queue is full
    assign in_ready = !((phase_reg == PH_BODY) && (pos_reg == POS_LAST) && qstat.full);
    assign accept   = in_valid && in_ready;
    assign tail_rel = pos_reg - POS_W'(PTS_END);
    assign word     = {rx_byte, low_reg};

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sub_next   = sub_reg;
        pt_next    = pt_reg;
        low_next   = low_reg;
        hdr_next   = hdr_reg;
        dist_next  = dist_reg;
        inten_next = inten_reg;
        push       = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SEEK1:
                begin
                    if (rx_byte == HDR_FIRST)
                    begin
                        phase_next = PH_SEEK2;
                    end
                end
                PH_SEEK2:
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        phase_next = PH_BODY;
                        pos_next   = '0;
                        sub_next   = SUB_LOW;
                        pt_next    = '0;
                    end
                    else if (rx_byte != HDR_FIRST)
                    begin
                        phase_next = PH_SEEK1;
                    end
                end
                PH_BODY:
                begin
                    if (pos_reg == POS_LAST)
                    begin
                        push       = 1'b1;
                        phase_next = PH_SEEK1;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                        if (int'(pos_reg) < PTS_BASE)
                        begin
                            if (!pos_reg[0])
                            begin
                                low_next = rx_byte;
                            end
                            else
                            begin
                                hdr_next[{1'b0, pos_reg[1]}] = word;
                            end
                        end
                        else if (int'(pos_reg) < PTS_END)
                        begin
                            unique case (sub_reg)
                                SUB_LOW:
                                begin
                                    low_next = rx_byte;
                                    sub_next = SUB_HIGH;
                                end
                                SUB_HIGH:
                                begin
                                    dist_next[pt_reg] = word;
                                    sub_next          = SUB_INT;
                                end
                                SUB_INT:
                                begin
                                    inten_next[pt_reg] = rx_byte;
                                    sub_next           = SUB_LOW;
                                    if (pt_reg != PT_LAST)
                                    begin
                                        pt_next = pt_reg + 1'b1;
                                    end
                                end
                                default:
                                begin
                                    sub_next = SUB_LOW;
                                end
                            endcase
                        end
                        else if (int'(pos_reg) < PTS_END + 4)
                        begin
                            if (!tail_rel[0])
                            begin
                                low_next = rx_byte;
                            end
                            else
                            begin
                                hdr_next[{1'b1, tail_rel[1]}] = word;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SEEK1;
                end
            endcase
        end
    end

    always_comb
    begin
        frame.speed       = hdr_reg[0];
        frame.sweep_start = hdr_reg[1];
        frame.sweep_stop  = hdr_reg[2];
        frame.frame_time  = hdr_reg[3];
        frame.crc         = rx_byte;
        for (int k = 0; k < POINTS_PER_FRAME; k++)
        begin
            frame.points[k].distance  = dist_reg[k];
            frame.points[k].intensity = inten_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK1;
            pos_reg   <= '0;
            sub_reg   <= SUB_LOW;
            pt_reg    <= '0;
            low_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sub_reg   <= sub_next;
            pt_reg    <= pt_next;
            low_reg   <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg   <= hdr_next;
        dist_reg  <= dist_next;
        inten_reg <= inten_next;
    end

endmodule

[design/lfp_queue.sv]
module lfp_queue
    import lfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  lfp_frame_t wr_frame,
    input  logic       pop,
    output lfp_frame_t rd_frame,
    output lfp_qstat_t qstat
);

    localparam logic [FQ_PTR_W-1:0] PTR_LAST = FQ_PTR_W'(FQ_DEPTH - 1);

    lfp_frame_t          mem_reg [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FQ_CNT_W-1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == FQ_CNT_W'(FQ_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign rd_frame    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_frame;
        end
    end

endmodule

[design/lfp_back.sv]
module lfp_back
    import lfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lfp_frame_t       head,
    input  lfp_qstat_t       qstat,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data,
    output logic             out_last
);

    localparam logic [IDX_W-1:0] PT_LAST = IDX_W'(POINTS_PER_FRAME - 1);

    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic             last_reg;
    logic [OUT_W-1:0] data_reg;
    logic             load;
    lfp_point_t       pt;

    assign load = !qstat.empty && (!valid_reg || out_ready);
    assign pop  = load && (cnt_reg == PT_LAST);
    assign pt   = head.points[cnt_reg];

    always_comb
    begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = (cnt_reg == PT_LAST) ? '0 : cnt_reg + 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {4'b0000, pt.intensity, pt.distance, 4'(cnt_reg), head.crc,
                         head.frame_time, head.sweep_stop, head.sweep_start, head.speed};
            last_reg <= (cnt_reg == PT_LAST);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

[design/lidar_frame_parser.sv]
// Byte-serial parser for 47-byte lidar frames. Feed one received serial byte per
// request on the slave side; the parser hunts for the header 0x54 0x2C (a byte
// other than 0x2C after 0x54 is re-examined as a possible header start), then
// collects the 45 body bytes: little-endian speed and start angle, twelve points
// of 16-bit distance plus 8-bit intensity, end angle, timestamp and CRC. Header
// bytes inside the body are plain data. When the CRC byte arrives the frame is
// handed to a two-frame queue and twelve point records go out on the master side,
// one per cycle while tready is high, each carrying the frame fields; tlast marks
// the twelfth. The CRC is passed on unchecked and angles stay raw, in units of
// 0.01 degree. Rate: one byte per cycle, always, except that the CRC byte waits
// while both queue slots hold frames not yet drained; the record emitter drains
// one record per cycle from its output register while tready is high. With the
// emitter idle, the CRC byte pushes the frame into a queue slot, and its first
// record is then loaded into the output register, from which it goes out valid.
module lidar_frame_parser
    import lfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // [15:0] rotation_speed, [31:16] sweep_start,
                                             // [47:32] sweep_stop, [63:48] frame_time,
                                             // [71:64] frame_crc, [75:72] point_index,
                                             // [91:76] distance, [99:92] intensity,
                                             // [103:100] zero
    output logic             m_axis_tlast    // last_point
);

    lfp_frame_t push_frame;
    lfp_frame_t head_frame;
    lfp_qstat_t qstat;
    logic       push;
    logic       pop;

    // Parse bytes, keep the frame being collected
    lfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .rx_byte  (s_axis_tdata[7:0]),
        .qstat    (qstat),
        .push     (push),
        .frame    (push_frame)
    );

    // Hold finished frames until the emitter gets to them
    lfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_frame (push_frame),
        .pop      (pop),
        .rd_frame (head_frame),
        .qstat    (qstat)
    );

    // Emit one point record per cycle from the head frame while the master side is ready
    lfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_frame),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // A frame is never pushed onto a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !qstat.full)
        else $error("frame pushed while queue full");

    // A pushed frame is visible in the queue next cycle
    assert property (@(posedge clk) disable iff (!rst_n) push |=> !qstat.empty)
        else $error("queue empty right after a push");

    // The flagged record is always the final point of its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[75:72] == 4'(POINTS_PER_FRAME - 1)))
        else $error("last record carries wrong point index");

    // Nothing is popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule
